FILE: hdl/register_write_log_encoder_unit_assert.svh
// Assertion helpers for the register write log encoder.
`ifndef REGISTER_WRITE_LOG_ENCODER_UNIT_ASSERT_SVH
`define REGISTER_WRITE_LOG_ENCODER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RWLE_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define RWLE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/rwle_pkg.sv
`timescale 1ns / 1ps

package rwle_pkg;

   // Sizing
   localparam int REG_COUNT   = 512;
   localparam int WAIT_CHUNK  = 65535;
   localparam int MAX_WAITS   = 63;
   localparam int ADDR_W      = 9;
   localparam int IDX_W       = $clog2(REG_COUNT);
   localparam int DELAY_LIMIT = MAX_WAITS * WAIT_CHUNK;
   localparam int PEND_W      = $clog2(DELAY_LIMIT + 1);
   localparam int CHUNK_W     = 16;

   // Input operations
   localparam logic [1:0] OP_WRITE  = 2'd0;
   localparam logic [1:0] OP_DELAY  = 2'd1;
   localparam logic [1:0] OP_FINISH = 2'd2;

   // Output opcodes
   localparam logic [7:0] CMD_PORT0 = 8'h5E;
   localparam logic [7:0] CMD_PORT1 = 8'h5F;
   localparam logic [7:0] CMD_WAIT  = 8'h61;
   localparam logic [7:0] CMD_END   = 8'h66;

   localparam logic [1:0] BYTES_LONG  = 2'd3;
   localparam logic [1:0] BYTES_SHORT = 2'd1;

   typedef struct packed {
      logic [1:0]        operation;
      logic [ADDR_W-1:0] reg_addr;
      logic [7:0]        reg_data;
      logic [31:0]       delay_samples;
   } req_type;

   typedef struct packed {
      logic [7:0]  command;
      logic [7:0]  arg_first;
      logic [7:0]  arg_second;
      logic [1:0]  byte_count;
      logic [31:0] total_samples;
      logic        last;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic clear_wr;
      logic capture;
      logic mem_write;
      logic add_delay;
      logic start_flush;
      logic load_wait;
      logic load_final;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [1:0] op;
      logic       drop;
      logic       pend_nz;
      logic       last_chunk;
      logic       out_free;
      logic       clear_last;
   } sts_type;

endpackage

FILE: hdl/register_write_log_encoder_unit.sv
// Register write log encoder: turns a trace of register writes and delays
// into VGM-style command beats.
// req channel (valid/ready): one item per beat - register write, add delay
// or finish. rsp channel (valid/ready): one command beat per result; last
// marks the final command caused by an item.
// Reset: the 512-entry shadow store is swept to zero, one entry per cycle,
// so req_ready stays low until the sweep ends after reset is released.
// Item flow: an item is taken in one cycle and decided in the next, when the
// shadow read returns. A write or finish with no pending delay puts its
// command in the output register once that register is free, and the
// block returns to idle for the next item. Delay items and dropped writes
// return to idle without a command. A flush puts one wait command per chunk
// (up to 63) and then the closing command in the output register.
// Stall: the output register holds one beat; while rsp_ready is low and it
// is full the engine waits, and no new item is taken until the current
// item's commands are all loaded.
`timescale 1ns / 1ps

module register_write_log_encoder_unit import rwle_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

`include "register_write_log_encoder_unit_assert.svh"

   cmd_type cmd;
   sts_type sts;

   rwle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rwle_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // No item is taken while the shadow store is being cleared
   `RWLE_ASSERT_IMPL(a_no_accept_in_clear, clock, reset, cmd.clear_wr, !req_ready,
      "item accepted during clear sweep")

   // A command is only loaded into a free output register
   `RWLE_ASSERT_IMPL(a_load_when_free, clock, reset, cmd.load_wait || cmd.load_final,
      sts.out_free, "result loaded over an untaken beat")

   // A wait beat is never the last beat of an item
   `RWLE_ASSERT_IMPL(a_wait_not_last, clock, reset,
      rsp_valid && rsp_payload.command == CMD_WAIT, !rsp_payload.last,
      "wait command flagged as last")

   // Loading a wait always leaves the datapath with a valid beat next cycle
   `RWLE_ASSERT_NEXT(a_wait_shows, clock, reset, cmd.load_wait, rsp_valid,
      "loaded wait beat not presented")

endmodule

FILE: hdl/rwle_ctrl.sv
`timescale 1ns / 1ps

module rwle_ctrl import rwle_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_DECIDE = 3'd2;
   localparam logic [2:0] S_FLUSH  = 3'd3;
   localparam logic [2:0] S_EMIT   = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (sts.op == OP_DELAY) begin
               cmd.add_delay = 1'b1;
               state_in      = S_IDLE;
            end else if (sts.op == OP_WRITE && sts.drop) begin
               state_in = S_IDLE;
            end else if (sts.op == OP_WRITE || sts.op == OP_FINISH) begin
               if (sts.pend_nz) begin
                  cmd.start_flush = 1'b1;
                  cmd.mem_write   = (sts.op == OP_WRITE);
                  state_in        = S_FLUSH;
               end else if (sts.out_free) begin
                  cmd.load_final = 1'b1;
                  cmd.mem_write  = (sts.op == OP_WRITE);
                  state_in       = S_IDLE;
               end
            end else begin
               state_in = S_IDLE;
            end
         end
         S_FLUSH: begin
            if (sts.out_free) begin
               cmd.load_wait = 1'b1;
               if (sts.last_chunk) begin
                  state_in = S_EMIT;
               end
            end
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.load_final = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hdl/rwle_dpath.sv
`timescale 1ns / 1ps

module rwle_dpath import rwle_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd,
   output sts_type sts,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   logic [7:0]        shadow_mem [REG_COUNT];
   req_type           item_ff;
   logic [7:0]        rd_data_ff;
   logic [IDX_W-1:0]  clr_cnt_ff;
   logic [PEND_W-1:0] pend_ff;
   logic [PEND_W-1:0] pend_in;
   logic [31:0]       total_ff;
   logic [31:0]       total_in;
   rsp_type           rsp_ff;
   rsp_type           rsp_in;
   logic              rsp_valid_ff;

   logic               in_range;
   logic [IDX_W-1:0]   item_idx;
   logic [CHUNK_W-1:0] chunk;
   logic               out_free;

   assign item_idx = item_ff.reg_addr[IDX_W-1:0];
   assign in_range = {1'b0, item_ff.reg_addr} < (ADDR_W + 1)'(REG_COUNT);
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Wait chunk: full chunk or remainder
   assign chunk = (pend_ff > PEND_W'(WAIT_CHUNK)) ? CHUNK_W'(WAIT_CHUNK)
                                                  : pend_ff[CHUNK_W-1:0];

   // Status to the controller
   always_comb begin
      sts.op         = item_ff.operation;
      sts.drop       = (item_ff.operation == OP_WRITE) && in_range &&
                       (rd_data_ff == item_ff.reg_data);
      sts.pend_nz    = (pend_ff != '0);
      sts.last_chunk = (pend_ff <= PEND_W'(WAIT_CHUNK));
      sts.out_free   = out_free;
      sts.clear_last = (clr_cnt_ff == IDX_W'(REG_COUNT - 1));
   end

   // Shadow store: clear sweep, update, registered read on capture
   always_ff @(posedge clock) begin
      if (cmd.clear_wr) begin
         shadow_mem[clr_cnt_ff] <= '0;
      end else if (cmd.mem_write && in_range) begin
         shadow_mem[item_idx] <= item_ff.reg_data;
      end
      if (cmd.capture) begin
         rd_data_ff <= shadow_mem[req_payload.reg_addr[IDX_W-1:0]];
      end
   end

   // Captured item
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_payload;
      end
   end

   // Pending delay and running total
   always_comb begin
      pend_in  = pend_ff;
      total_in = total_ff;
      if (cmd.add_delay) begin
         if (item_ff.delay_samples >= 32'(DELAY_LIMIT) - 32'(pend_ff)) begin
            pend_in = PEND_W'(DELAY_LIMIT);
         end else begin
            pend_in = pend_ff + item_ff.delay_samples[PEND_W-1:0];
         end
      end else if (cmd.load_wait) begin
         pend_in = pend_ff - PEND_W'(chunk);
      end
      if (cmd.start_flush) begin
         total_in = total_ff + 32'(pend_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff    <= '0;
         total_ff   <= '0;
         clr_cnt_ff <= '0;
      end else begin
         pend_ff  <= pend_in;
         total_ff <= total_in;
         if (cmd.clear_wr) begin
            clr_cnt_ff <= clr_cnt_ff + IDX_W'(1);
         end
      end
   end

   // Result beat assembly
   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.load_wait) begin
         rsp_in.command       = CMD_WAIT;
         rsp_in.arg_first     = chunk[7:0];
         rsp_in.arg_second    = chunk[15:8];
         rsp_in.byte_count    = BYTES_LONG;
         rsp_in.total_samples = '0;
         rsp_in.last          = 1'b0;
      end else if (cmd.load_final) begin
         rsp_in.last = 1'b1;
         if (item_ff.operation == OP_FINISH) begin
            rsp_in.command       = CMD_END;
            rsp_in.arg_first     = '0;
            rsp_in.arg_second    = '0;
            rsp_in.byte_count    = BYTES_SHORT;
            rsp_in.total_samples = total_ff;
         end else begin
            rsp_in.command       = item_ff.reg_addr[8] ? CMD_PORT1 : CMD_PORT0;
            rsp_in.arg_first     = item_ff.reg_addr[7:0];
            rsp_in.arg_second    = item_ff.reg_data;
            rsp_in.byte_count    = BYTES_LONG;
            rsp_in.total_samples = '0;
         end
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_wait || cmd.load_final) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
